// ===== hw/rtl/cckb_pkg.sv =====
// Shared types, constants and helpers for the clipped color-key blitter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cckb_pkg;

    // Screen and image geometry
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int MAX_IMAGE_DIM = 1024;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int ADDR_W  = 16;
    localparam int ORG_W   = 11;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = $clog2(MAX_IMAGE_DIM);
    localparam int DIM_W   = $clog2(MAX_IMAGE_DIM + 1);
    localparam int POS_W   = ((ORG_W > CNT_W + 1) ? ORG_W : CNT_W + 1) + 1;
    localparam int XW      = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int YW      = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [PIX_W-1:0] KEY_LOW  = 8'h00;
    localparam logic [PIX_W-1:0] KEY_HIGH = 8'hff;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_KEY_MODE     = 3'd4;

    typedef enum logic [1:0] {
        KEY_OPAQUE    = 2'd0,
        KEY_SKIP_ZERO = 2'd1,
        KEY_SKIP_BOTH = 2'd2
    } t_key_mode;

    typedef struct packed {
        logic [ORG_W-1:0] origin_x;
        logic [ORG_W-1:0] origin_y;
        logic [DIM_W-1:0] width;   // effective, already clamped
        logic [DIM_W-1:0] height;  // effective, already clamped
        logic [1:0]       key_mode;
    } t_cfg;

    // Classified pixel as it travels through the queue
    typedef struct packed {
        logic             we;
        logic             done;
        logic [PIX_W-1:0] pixel;
        logic [XW-1:0]    x;
        logic [YW-1:0]    y;
    } t_item;

    // Clamp a size to 1..MAX_IMAGE_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > MAX_IMAGE_DIM) begin
            r = DIM_W'(MAX_IMAGE_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/cckb_front.sv =====
// Front end: takes source pixels, tracks column and row, clips and keys.
// Depends on cckb_pkg.
`timescale 1ns / 1ps

module cckb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cckb_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_pixel,
    input  logic           i_q_full,
    output logic           o_push,
    output cckb_pkg::t_item o_item
);
    import cckb_pkg::*;

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic             col_last, row_last;
    logic signed [POS_W-1:0] dx, dy;
    logic             on_screen, keyed, we;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign col_last = ((CNT_W+1)'(r_col) + (CNT_W+1)'(1)) >= (CNT_W+1)'(i_cfg.width);
    assign row_last = ((CNT_W+1)'(r_row) + (CNT_W+1)'(1)) >= (CNT_W+1)'(i_cfg.height);

    assign dx = $signed({{(POS_W-ORG_W){i_cfg.origin_x[ORG_W-1]}}, i_cfg.origin_x})
              + $signed({{(POS_W-CNT_W){1'b0}}, r_col});
    assign dy = $signed({{(POS_W-ORG_W){i_cfg.origin_y[ORG_W-1]}}, i_cfg.origin_y})
              + $signed({{(POS_W-CNT_W){1'b0}}, r_row});

    assign on_screen = !dx[POS_W-1] && ($unsigned(dx) < POS_W'(SCREEN_WIDTH))
                    && !dy[POS_W-1] && ($unsigned(dy) < POS_W'(SCREEN_HEIGHT));

    always_comb begin
        unique case (i_cfg.key_mode)
            KEY_OPAQUE:    keyed = 1'b0;
            KEY_SKIP_ZERO: keyed = (i_pixel == KEY_LOW);
            default:       keyed = (i_pixel == KEY_LOW) || (i_pixel == KEY_HIGH);
        endcase
    end

    assign we = on_screen && !keyed;

    // Zero the payload of suppressed writes so the address comes out zero
    always_comb begin
        o_item.we    = we;
        o_item.done  = col_last && row_last;
        o_item.pixel = we ? i_pixel : '0;
        o_item.x     = we ? dx[XW-1:0] : '0;
        o_item.y     = we ? dy[YW-1:0] : '0;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== hw/rtl/cckb_queue.sv =====
// Short queue between front and back ends of the blitter.
// Depends on cckb_pkg.
`timescale 1ns / 1ps

module cckb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cckb_pkg::t_item i_item,
    input  logic            i_pop,
    output cckb_pkg::t_item o_item,
    output logic            o_full,
    output logic            o_empty
);
    import cckb_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_PTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (Q_PTR_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (Q_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/cckb_back.sv =====
// Back end: forms the framebuffer address and holds the output word.
// Depends on cckb_pkg.
`timescale 1ns / 1ps

module cckb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  cckb_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_addr,
    output logic [7:0]      o_pixel,
    output logic            o_we,
    output logic            o_done
);
    import cckb_pkg::*;

    logic              r_valid;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [PIX_W-1:0]  r_pixel;
    logic              r_we;
    logic              r_done;

    // Load a new word when the output register is free or being taken
    assign o_pop  = !i_q_empty && (!r_valid || i_ready);
    assign n_addr = ADDR_W'(32'(i_item.y) * 32'(SCREEN_WIDTH) + 32'(i_item.x));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr  <= n_addr;
            r_pixel <= i_item.pixel;
            r_we    <= i_item.we;
            r_done  <= i_item.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;
    assign o_pixel = r_pixel;
    assign o_we    = r_we;
    assign o_done  = r_done;

endmodule

// ===== hw/rtl/clipped_color_key_blitter.sv =====
// Top level of the clipped color-key blitter: configuration registers,
// front end, queue and back end. Depends on cckb_pkg and the cckb_* modules.
//
// Usage:
//   Source pixels enter on the slave stream (i_s_tdata, one 8-bit palette
//   index per word) in raster order. Every word yields one output word on the
//   master stream: tdata carries the framebuffer address and the pixel,
//   tuser is the write enable, tlast marks the image's final pixel.
//   A word whose destination falls off the 320x200 screen, or whose value is
//   keyed, comes out with tuser low and zero data.
//   Configuration is written through i_cfg_valid / i_cfg_index / i_cfg_data
//   (origin x, origin y, width, height, key mode); o_cfg_ready is always
//   high. Write it only while no word is in flight.
//   Path: an accepted word passes the queue, then the back-end output register.
//   Throughput: one word per cycle while i_m_tready is high, set by the
//   combinational classify step in the front end and the one-word output register in the back end.
//   Stall: when i_m_tready is low the output word holds; the four-entry
//   queue absorbs up to four more words before o_s_tready drops.
//   Reset (synchronous, active low) clears the counters, the queue and the
//   output valid, and returns registers to origin 0,0, size 1x1, opaque.
`timescale 1ns / 1ps

module clipped_color_key_blitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] source_pixel
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [15:0] write_address, [23:16] write_pixel
    output logic        o_m_tuser,   // [0] write_enable
    output logic        o_m_tlast,   // image_done
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import cckb_pkg::*;

    t_cfg  r_cfg;
    t_item front_item, q_item;
    logic  push, pop, q_full, q_empty;
    logic  cfg_we;
    logic [ADDR_W-1:0] back_addr;
    logic [PIX_W-1:0]  back_pixel;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Register file; sizes are clamped on write, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.width    <= DIM_W'(1);
            r_cfg.height   <= DIM_W'(1);
            r_cfg.key_mode <= KEY_OPAQUE;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_ORIGIN_X:     r_cfg.origin_x <= i_cfg_data[ORG_W-1:0];
                REG_ORIGIN_Y:     r_cfg.origin_y <= i_cfg_data[ORG_W-1:0];
                REG_IMAGE_WIDTH:  r_cfg.width    <= eff_dim(i_cfg_data);
                REG_IMAGE_HEIGHT: r_cfg.height   <= eff_dim(i_cfg_data);
                REG_KEY_MODE:     r_cfg.key_mode <= i_cfg_data[1:0];
                default:          r_cfg          <= r_cfg;
            endcase
        end
    end

    // Front end: count, clip, key
    cckb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_pixel  (i_s_tdata),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (front_item)
    );

    // Decouple the two ends
    cckb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: address and output register
    cckb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_addr    (back_addr),
        .o_pixel   (back_pixel),
        .o_we      (o_m_tuser),
        .o_done    (o_m_tlast)
    );

    assign o_m_tdata = {back_pixel, back_addr};

endmodule

// ===== hw/rtl/cckb_checker.sv =====
// Port-level checks for the clipped color-key blitter, bound to the top level.
// Depends on cckb_pkg.
`timescale 1ns / 1ps

module cckb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);
    import cckb_pkg::*;

    localparam longint SCREEN_PIXELS = longint'(SCREEN_WIDTH) * longint'(SCREEN_HEIGHT);
    localparam bit     ADDR_WRAPS    = SCREEN_PIXELS > 65536;

    // Hold a stalled output word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // Suppressed writes carry zero data
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("suppressed write carries data");

    // Enabled writes land on the screen
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> ADDR_WRAPS
            || (longint'(o_m_tdata[15:0]) < SCREEN_PIXELS))
        else $error("write address off screen");

    // Nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind clipped_color_key_blitter cckb_checker u_cckb_checker (.*);
